[hw/rtl/rvcc_pkg.sv]
// rvcc_pkg: types, constants and the decode table of the regulator voltage code converter
// no dependencies; used by the channel interfaces and the converter top level
package rvcc_pkg;

  localparam int unsigned CodeW = 5;
  localparam int unsigned UvW   = 22;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DCDC   = 2'd0,
    KIND_LDO123 = 2'd1,
    KIND_LDO45  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CLAMP = 2'd1,
    ST_KIND  = 2'd2
  } status_e;

  // segment breakpoints in uV
  localparam logic [UvW-1:0] UvDcdcMin = 22'd800000;
  localparam logic [UvW-1:0] UvLdo45Min = 22'd1200000;
  localparam logic [UvW-1:0] UvLdo123Min = 22'd1700000;
  localparam logic [UvW-1:0] Uv1900 = 22'd1900000;
  localparam logic [UvW-1:0] Uv2600 = 22'd2600000;
  localparam logic [UvW-1:0] Uv3000 = 22'd3000000;
  localparam logic [UvW-1:0] Uv3100 = 22'd3100000;
  localparam logic [UvW-1:0] Uv3300 = 22'd3300000;
  localparam logic [UvW-1:0] UvStep50 = 22'd50000;
  localparam logic [UvW-1:0] UvStep100 = 22'd100000;

  // segment start codes
  localparam logic [CodeW-1:0] CodeMax = 5'h1f;
  localparam logic [CodeW-1:0] CodeDcdcStart = 5'h01;
  localparam logic [CodeW-1:0] CodeL123Seg0 = 5'h0a;
  localparam logic [CodeW-1:0] CodeL123Seg1 = 5'h0e;
  localparam logic [CodeW-1:0] CodeL123Seg2 = 5'h15;
  localparam logic [CodeW-1:0] CodeL123Seg3 = 5'h1d;
  localparam logic [CodeW-1:0] CodeL123Gap = 5'h1e;
  localparam logic [CodeW-1:0] CodeL45Seg0 = 5'h05;
  localparam logic [CodeW-1:0] CodeL45Seg1 = 5'h13;
  localparam logic [CodeW-1:0] CodeL45Seg2 = 5'h1a;

  // 50000 = 16 * 3125; offset >> 4 is below 2^18, and with this reciprocal
  // (x * RecipMul) >> RecipShift equals x / 3125 exactly over that range
  localparam int unsigned DivPreShift = 4;
  localparam int unsigned DivInW = UvW - DivPreShift;
  localparam int unsigned RecipShift = 30;
  localparam int unsigned RecipW = 19;
  localparam logic [RecipW-1:0] RecipMul = 19'd343598;
  localparam int unsigned ProdW = DivInW + RecipW;
  localparam int unsigned QuotW = ProdW - RecipShift;

  typedef struct packed {
    logic                 use_div;
    logic                 step100;
    logic [CodeW-1:0]     start;
    logic [DivInW-1:0]    div_in;
    logic [CodeW-1:0]     code;
    logic [UvW-1:0]       uv;
    status_e              status;
  } s1_t;

  typedef struct packed {
    logic                 use_div;
    logic                 step100;
    logic [CodeW-1:0]     start;
    logic [ProdW-1:0]     prod;
    logic [CodeW-1:0]     code;
    logic [UvW-1:0]       uv;
    status_e              status;
  } s2_t;

  // voltage of a selector code; codes below a kind's start give its minimum
  function automatic logic [UvW-1:0] dec_uv(kind_e kind, logic [CodeW-1:0] code);
    logic [UvW-1:0] c;
    logic [UvW-1:0] res;
    c = UvW'(code);
    res = '0;
    unique case (kind)
      KIND_DCDC: begin
        if (code > CodeDcdcStart) res = (c - 22'd1) * UvStep50 + UvDcdcMin;
        else res = UvDcdcMin;
      end
      KIND_LDO123: begin
        if (code == CodeMax) res = Uv3300;
        else if (code >= CodeL123Seg3) res = (c - UvW'(CodeL123Seg3)) * UvStep100 + Uv3000;
        else if (code >= CodeL123Seg2) res = (c - UvW'(CodeL123Seg2)) * UvStep50 + Uv2600;
        else if (code >= CodeL123Seg1) res = (c - UvW'(CodeL123Seg1)) * UvStep100 + Uv1900;
        else if (code >= CodeL123Seg0) res = (c - UvW'(CodeL123Seg0)) * UvStep50 + UvLdo123Min;
        else res = UvLdo123Min;
      end
      KIND_LDO45: begin
        if (code >= CodeL45Seg2) res = (c - UvW'(CodeL45Seg2)) * UvStep50 + Uv2600;
        else if (code >= CodeL45Seg1) res = (c - UvW'(CodeL45Seg1)) * UvStep100 + Uv1900;
        else if (code >= CodeL45Seg0) res = (c - UvW'(CodeL45Seg0)) * UvStep50 + UvLdo45Min;
        else res = UvLdo45Min;
      end
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

[hw/rtl/rvcc_if.sv]
// rvcc_if: valid/ready channel interfaces for converter requests and results
// depends on rvcc_pkg for field widths
interface rvcc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [1:0]                    reg_kind;
  logic [rvcc_pkg::UvW-1:0]      microvolts_in;
  logic [rvcc_pkg::CodeW-1:0]    code_in;

  modport source (output valid, cmd, reg_kind, microvolts_in, code_in, input ready);
  modport sink (input valid, cmd, reg_kind, microvolts_in, code_in, output ready);
endinterface

interface rvcc_out_if;
  logic                          valid;
  logic                          ready;
  logic [rvcc_pkg::CodeW-1:0]    code_out;
  logic [rvcc_pkg::UvW-1:0]      microvolts_out;
  logic [1:0]                    status;

  modport source (output valid, code_out, microvolts_out, status, input ready);
  modport sink (input valid, code_out, microvolts_out, status, output ready);
endinterface

[hw/rtl/regulator_voltage_code_converter_unit.sv]
// regulator_voltage_code_converter_unit: three-stage encode/decode pipeline
// depends on rvcc_pkg and the channel interfaces in rvcc_if.sv
//
// Converts a target voltage in uV to a regulator selector code (encode) or a
// code to its voltage (decode) for the dcdc, ldo 1-3 and ldo 4-5 tables. Every
// request gives exactly one result beat. A new request is taken every cycle
// while results drain. The result passes through the three register stages:
// segment select and offset subtract, the reciprocal multiply that divides the
// offset by 50 mV, and the final code add with range clamp, which also forms
// the output register.
module regulator_voltage_code_converter_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  rvcc_in_if.sink      in_i,
  rvcc_out_if.source   out_o
);

  rvcc_pkg::s1_t s1_d, s1_q;
  rvcc_pkg::s2_t s2_d, s2_q;
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_ready, s2_ready, s3_ready;
  logic [rvcc_pkg::UvW-1:0] base;
  logic [rvcc_pkg::UvW-1:0] offset;
  rvcc_pkg::kind_e kind;
  logic [rvcc_pkg::UvW-1:0] v;
  logic [rvcc_pkg::QuotW-1:0] quot;
  logic [rvcc_pkg::QuotW:0] code_sum;
  logic [rvcc_pkg::CodeW-1:0] code_d, code_q;
  logic [rvcc_pkg::UvW-1:0] uv_q;
  rvcc_pkg::status_e status_d, status_q;

  assign s3_ready = !s3_valid_q || out_o.ready;
  assign s2_ready = !s2_valid_q || s3_ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;

  assign kind = rvcc_pkg::kind_e'(in_i.reg_kind);
  assign v = in_i.microvolts_in;

  // stage 1: pick the segment, its base and start code, or decode the code to its voltage
  always_comb begin
    s1_d = '0;
    s1_d.status = rvcc_pkg::ST_OK;
    base = '0;
    if (kind == rvcc_pkg::KIND_NONE) begin
      s1_d.status = rvcc_pkg::ST_KIND;
    end else if (rvcc_pkg::cmd_e'(in_i.cmd) == rvcc_pkg::CMD_DECODE) begin
      s1_d.uv = rvcc_pkg::dec_uv(kind, in_i.code_in);
    end else begin
      unique case (kind)
        rvcc_pkg::KIND_DCDC: begin
          if (v < rvcc_pkg::UvDcdcMin) begin
            s1_d.code = rvcc_pkg::CodeDcdcStart;
            s1_d.status = rvcc_pkg::ST_CLAMP;
          end else begin
            s1_d.use_div = 1'b1;
            s1_d.start = rvcc_pkg::CodeDcdcStart;
            base = rvcc_pkg::UvDcdcMin;
          end
        end
        rvcc_pkg::KIND_LDO123: begin
          priority if (v < rvcc_pkg::UvLdo123Min) begin
            s1_d.code = rvcc_pkg::CodeL123Seg0;
            s1_d.status = rvcc_pkg::ST_CLAMP;
          end else if (v <= rvcc_pkg::Uv1900) begin
            s1_d.use_div = 1'b1;
            s1_d.start = rvcc_pkg::CodeL123Seg0;
            base = rvcc_pkg::UvLdo123Min;
          end else if (v <= rvcc_pkg::Uv2600) begin
            s1_d.use_div = 1'b1;
            s1_d.step100 = 1'b1;
            s1_d.start = rvcc_pkg::CodeL123Seg1;
            base = rvcc_pkg::Uv1900;
          end else if (v <= rvcc_pkg::Uv3000) begin
            s1_d.use_div = 1'b1;
            s1_d.start = rvcc_pkg::CodeL123Seg2;
            base = rvcc_pkg::Uv2600;
          end else if (v <= rvcc_pkg::Uv3100) begin
            s1_d.use_div = 1'b1;
            s1_d.step100 = 1'b1;
            s1_d.start = rvcc_pkg::CodeL123Seg3;
            base = rvcc_pkg::Uv3000;
          end else if (v < rvcc_pkg::Uv3300) begin
            // gap between 3.1 V and 3.3 V rounds down
            s1_d.code = rvcc_pkg::CodeL123Gap;
          end else if (v == rvcc_pkg::Uv3300) begin
            s1_d.code = rvcc_pkg::CodeMax;
          end else begin
            s1_d.code = rvcc_pkg::CodeMax;
            s1_d.status = rvcc_pkg::ST_CLAMP;
          end
        end
        rvcc_pkg::KIND_LDO45: begin
          priority if (v < rvcc_pkg::UvLdo45Min) begin
            s1_d.code = rvcc_pkg::CodeL45Seg0;
            s1_d.status = rvcc_pkg::ST_CLAMP;
          end else if (v <= rvcc_pkg::Uv1900) begin
            s1_d.use_div = 1'b1;
            s1_d.start = rvcc_pkg::CodeL45Seg0;
            base = rvcc_pkg::UvLdo45Min;
          end else if (v <= rvcc_pkg::Uv2600) begin
            s1_d.use_div = 1'b1;
            s1_d.step100 = 1'b1;
            s1_d.start = rvcc_pkg::CodeL45Seg1;
            base = rvcc_pkg::Uv1900;
          end else begin
            s1_d.use_div = 1'b1;
            s1_d.start = rvcc_pkg::CodeL45Seg2;
            base = rvcc_pkg::Uv2600;
          end
        end
        default: s1_d.status = rvcc_pkg::ST_KIND;
      endcase
    end
    offset = v - base;
    s1_d.div_in = offset[rvcc_pkg::UvW-1:rvcc_pkg::DivPreShift];
  end

  // stage 2: divide by 50 mV through the reciprocal
  always_comb begin
    s2_d.use_div = s1_q.use_div;
    s2_d.step100 = s1_q.step100;
    s2_d.start = s1_q.start;
    s2_d.prod = rvcc_pkg::ProdW'(s1_q.div_in) * rvcc_pkg::ProdW'(rvcc_pkg::RecipMul);
    s2_d.code = s1_q.code;
    s2_d.uv = s1_q.uv;
    s2_d.status = s1_q.status;
  end

  // stage 3: halve for 100 mV segments, add start code, clamp at the top
  always_comb begin
    quot = s2_q.prod[rvcc_pkg::ProdW-1:rvcc_pkg::RecipShift];
    if (s2_q.step100) quot = quot >> 1;
    code_sum = (rvcc_pkg::QuotW + 1)'(s2_q.start) + (rvcc_pkg::QuotW + 1)'(quot);
    code_d = s2_q.code;
    status_d = s2_q.status;
    if (s2_q.use_div) begin
      if (code_sum > (rvcc_pkg::QuotW + 1)'(rvcc_pkg::CodeMax)) begin
        code_d = rvcc_pkg::CodeMax;
        status_d = rvcc_pkg::ST_CLAMP;
      end else begin
        code_d = code_sum[rvcc_pkg::CodeW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_i.valid;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_i.valid) s1_q <= s1_d;
    if (s2_ready && s1_valid_q) s2_q <= s2_d;
    if (s3_ready && s2_valid_q) begin
      code_q <= code_d;
      uv_q <= s2_q.uv;
      status_q <= status_d;
    end
  end

  assign out_o.valid = s3_valid_q;
  assign out_o.code_out = code_q;
  assign out_o.microvolts_out = uv_q;
  assign out_o.status = status_q;

  // an accepted beat always lands in stage 1
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s1_valid_q)
    else $error("accepted beat missing from stage 1");

  // a stalled middle stage keeps its beat
  a_s2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s3_ready) |=> (s2_valid_q && $stable(s2_q)))
    else $error("stage 2 beat lost under stall");

  // unsupported kind gives all-zero fields
  a_kind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == rvcc_pkg::ST_KIND) |->
      (out_o.code_out == '0 && out_o.microvolts_out == '0))
    else $error("unsupported kind with nonzero result");

  // clamping only happens on encode, which never reports a voltage
  a_clamp_encode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == rvcc_pkg::ST_CLAMP) |-> (out_o.microvolts_out == '0))
    else $error("clamp status on a decode result");

endmodule

[test/tb.sv]
// tb: self-checking testbench for regulator_voltage_code_converter_unit
// depends on rvcc_pkg and rvcc_if.sv; predicts every conversion and checks each result beat
`timescale 1ns / 100ps

module tb;

  localparam int unsigned RandomItems = 1750;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    rvcc_pkg::cmd_e                 cmd;
    rvcc_pkg::kind_e                kind;
    logic [rvcc_pkg::UvW-1:0]       uv;
    logic [rvcc_pkg::CodeW-1:0]     code;
  } conv_req_t;

  typedef struct packed {
    logic [rvcc_pkg::CodeW-1:0]     code;
    logic [rvcc_pkg::UvW-1:0]       uv;
    rvcc_pkg::status_e              status;
  } conv_res_t;

  class conversion_checker;
    conv_res_t   expected_results[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned n_encode;
    int unsigned n_decode;
    int unsigned n_clamp;
    int unsigned n_kind;

    function conv_res_t predict_conversion(conv_req_t r);
      conv_res_t   res;
      int unsigned v;
      int unsigned c;
      int unsigned q;
      int unsigned uv;
      res.code = '0;
      res.uv = '0;
      res.status = rvcc_pkg::ST_OK;
      v = r.uv;
      c = r.code;
      q = 0;
      uv = 0;
      if (r.kind == rvcc_pkg::KIND_NONE) begin
        res.status = rvcc_pkg::ST_KIND;
      end else if (r.cmd == rvcc_pkg::CMD_ENCODE) begin
        case (r.kind)
          rvcc_pkg::KIND_DCDC: begin
            if (v < 800000) begin
              q = 1;
              res.status = rvcc_pkg::ST_CLAMP;
            end else begin
              q = (v - 800000) / 50000 + 1;
              if (q > 31) begin
                q = 31;
                res.status = rvcc_pkg::ST_CLAMP;
              end
            end
          end
          rvcc_pkg::KIND_LDO123: begin
            if (v < 1700000) begin
              q = 10;
              res.status = rvcc_pkg::ST_CLAMP;
            end else if (v <= 1900000) q = (v - 1700000) / 50000 + 10;
            else if (v <= 2600000) q = (v - 1900000) / 100000 + 14;
            else if (v <= 3000000) q = (v - 2600000) / 50000 + 21;
            else if (v <= 3100000) q = (v - 3000000) / 100000 + 29;
            // nothing between 3.1 V and 3.3 V, round down to the 3.1 V code
            else if (v < 3300000) q = 30;
            else begin
              q = 31;
              if (v != 3300000) res.status = rvcc_pkg::ST_CLAMP;
            end
          end
          default: begin
            if (v < 1200000) begin
              q = 5;
              res.status = rvcc_pkg::ST_CLAMP;
            end else if (v <= 1900000) q = (v - 1200000) / 50000 + 5;
            else if (v <= 2600000) q = (v - 1900000) / 100000 + 19;
            else begin
              q = (v - 2600000) / 50000 + 26;
              if (q > 31) begin
                q = 31;
                res.status = rvcc_pkg::ST_CLAMP;
              end
            end
          end
        endcase
        res.code = q[rvcc_pkg::CodeW-1:0];
      end else begin
        case (r.kind)
          rvcc_pkg::KIND_DCDC: uv = (c > 1) ? (c - 1) * 50000 + 800000 : 800000;
          rvcc_pkg::KIND_LDO123: begin
            if (c == 31) uv = 3300000;
            else if (c >= 29) uv = (c - 29) * 100000 + 3000000;
            else if (c >= 21) uv = (c - 21) * 50000 + 2600000;
            else if (c >= 14) uv = (c - 14) * 100000 + 1900000;
            else if (c >= 10) uv = (c - 10) * 50000 + 1700000;
            else uv = 1700000;
          end
          default: begin
            if (c >= 26) uv = (c - 26) * 50000 + 2600000;
            else if (c >= 19) uv = (c - 19) * 100000 + 1900000;
            else if (c >= 5) uv = (c - 5) * 50000 + 1200000;
            else uv = 1200000;
          end
        endcase
        res.uv = uv[rvcc_pkg::UvW-1:0];
      end
      return res;
    endfunction

    function void note_request(conv_req_t r);
      conv_res_t res;
      res = predict_conversion(r);
      expected_results.push_back(res);
      if (r.cmd == rvcc_pkg::CMD_ENCODE) n_encode++;
      else n_decode++;
      if (res.status == rvcc_pkg::ST_CLAMP) n_clamp++;
      if (res.status == rvcc_pkg::ST_KIND) n_kind++;
    endfunction

    function void check_result(logic [rvcc_pkg::CodeW-1:0] code,
                               logic [rvcc_pkg::UvW-1:0] uv, logic [1:0] status);
      conv_res_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing pending: code_out %0d microvolts_out %0d status %0d",
               code, uv, status);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (code !== want.code) begin
        $error("code_out: expected %0d, got %0d", want.code, code);
        errors++;
      end
      if (uv !== want.uv) begin
        $error("microvolts_out: expected %0d, got %0d", want.uv, uv);
        errors++;
      end
      if (status !== 2'(want.status)) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  int unsigned src_idle;
  int unsigned snk_idle;
  int unsigned cycle_cnt;

  conversion_checker conv_chk = new();

  rvcc_in_if  in_if ();
  rvcc_out_if out_if ();

  regulator_voltage_code_converter_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               conv_chk.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side: check accepted beats, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      conv_chk.check_result(out_if.code_out, out_if.microvolts_out, out_if.status);
    out_if.ready <= rst_n && ($urandom_range(99) >= snk_idle);
  end

  task automatic send_item(rvcc_pkg::cmd_e cmd, rvcc_pkg::kind_e kind,
                           logic [rvcc_pkg::UvW-1:0] uv, logic [rvcc_pkg::CodeW-1:0] code);
    conv_req_t req;
    req = '{cmd: cmd, kind: kind, uv: uv, code: code};
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.cmd           <= cmd;
    in_if.reg_kind      <= kind;
    in_if.microvolts_in <= uv;
    in_if.code_in       <= code;
    do @(posedge clk); while (!in_if.ready);
    conv_chk.note_request(req);
  endtask

  task automatic encode(rvcc_pkg::kind_e kind, int unsigned uv);
    send_item(rvcc_pkg::CMD_ENCODE, kind, uv[rvcc_pkg::UvW-1:0],
              rvcc_pkg::CodeW'($urandom_range(31)));
  endtask

  task automatic decode(rvcc_pkg::kind_e kind, int unsigned code);
    send_item(rvcc_pkg::CMD_DECODE, kind, rvcc_pkg::UvW'($urandom_range(4194303)),
              code[rvcc_pkg::CodeW-1:0]);
  endtask

  task automatic send_random();
    rvcc_pkg::cmd_e           cmd;
    rvcc_pkg::kind_e          kind;
    logic [rvcc_pkg::UvW-1:0] uv;
    int unsigned              sel;
    cmd = rvcc_pkg::cmd_e'($urandom_range(1));
    kind = ($urandom_range(99) < 8) ? rvcc_pkg::KIND_NONE :
           rvcc_pkg::kind_e'($urandom_range(2));
    sel = $urandom_range(99);
    // mostly voltages around the tables, with breakpoints and their neighbors
    if (sel < 15) uv = rvcc_pkg::UvW'($urandom_range(4194303));
    else if (sel < 35) uv = rvcc_pkg::UvW'(50000 * $urandom_range(12, 70));
    else if (sel < 45) uv = rvcc_pkg::UvW'(50000 * $urandom_range(12, 70) - 1);
    else uv = rvcc_pkg::UvW'($urandom_range(600000, 3500000));
    send_item(cmd, kind, uv, rvcc_pkg::CodeW'($urandom_range(31)));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (conv_chk.pending() != 0) @(posedge clk);
  endtask

  initial begin
    in_if.valid         = 1'b0;
    in_if.cmd           = rvcc_pkg::CMD_ENCODE;
    in_if.reg_kind      = rvcc_pkg::KIND_DCDC;
    in_if.microvolts_in = '0;
    in_if.code_in       = '0;
    out_if.ready        = 1'b0;
    rst_n               = 1'b0;
    src_idle            = 18;
    snk_idle            = 46;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // table ends, clamps on both sides, the ldo 1-3 gap below 3.3 V and unsupported kinds
    encode(rvcc_pkg::KIND_DCDC, 0);
    encode(rvcc_pkg::KIND_DCDC, 799999);
    encode(rvcc_pkg::KIND_DCDC, 800000);
    encode(rvcc_pkg::KIND_DCDC, 2349999);
    encode(rvcc_pkg::KIND_DCDC, 2350000);
    encode(rvcc_pkg::KIND_DCDC, 4194303);
    encode(rvcc_pkg::KIND_LDO123, 1699999);
    encode(rvcc_pkg::KIND_LDO123, 1900000);
    encode(rvcc_pkg::KIND_LDO123, 2650000);
    encode(rvcc_pkg::KIND_LDO123, 3100000);
    encode(rvcc_pkg::KIND_LDO123, 3299999);
    encode(rvcc_pkg::KIND_LDO123, 3300000);
    encode(rvcc_pkg::KIND_LDO123, 3300001);
    encode(rvcc_pkg::KIND_LDO45, 1199999);
    encode(rvcc_pkg::KIND_LDO45, 2850000);
    encode(rvcc_pkg::KIND_LDO45, 2900000);
    encode(rvcc_pkg::KIND_NONE, 1800000);
    decode(rvcc_pkg::KIND_DCDC, 0);
    decode(rvcc_pkg::KIND_DCDC, 31);
    decode(rvcc_pkg::KIND_LDO123, 9);
    decode(rvcc_pkg::KIND_LDO123, 20);
    decode(rvcc_pkg::KIND_LDO123, 31);
    decode(rvcc_pkg::KIND_LDO45, 4);
    decode(rvcc_pkg::KIND_LDO45, 31);
    decode(rvcc_pkg::KIND_NONE, 31);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      src_idle = (phase == 0) ? 18 : (phase == 1) ? 46 : 0;
      snk_idle = (phase == 0) ? 46 : (phase == 1) ? 18 : 0;
      repeat (RandomItems / 3) send_random();
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    $display("checked %0d results: %0d encodes, %0d decodes", conv_chk.checked,
             conv_chk.n_encode, conv_chk.n_decode);
    $display("  %0d clamped voltages, %0d unsupported kinds", conv_chk.n_clamp,
             conv_chk.n_kind);
    if (conv_chk.errors == 0 && conv_chk.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/rvcc_pkg.sv
hw/rtl/rvcc_if.sv
hw/rtl/regulator_voltage_code_converter_unit.sv
test/tb.sv
